// ===== hw/rtl/psi_pkg.sv =====
// Shared types, codes and helpers for the path spline interpolator.
// Used by path_spline_interpolator; no dependencies of its own.
package psi_pkg;

  localparam int unsigned OneQ = 65536;
  localparam int unsigned LocalLimit = 262144;

  localparam logic [1:0] ModeLinear = 2'd0;
  localparam logic [1:0] ModeCatmull = 2'd1;
  localparam logic [1:0] ModeBezier = 2'd2;

  localparam logic [1:0] StatusOk = 2'd0;
  localparam logic [1:0] StatusFull = 2'd1;
  localparam logic [1:0] StatusShort = 2'd2;

  localparam logic KindAppend = 1'b0;

  // Saturate a wide signed value to the signed 32-bit range.
  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'sd2147483647) begin
      r = 32'sh7fffffff;
    end else if (v < -64'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

// ===== hw/rtl/path_spline_interpolator.sv =====
// Path spline interpolator: point table plus linear / Catmull-Rom evaluation.
// An append writes the table. An evaluate searches for the segment, reads and captures its
// start time, divides (not for a short span), reads the control points and multiplies; a
// query past the end returns once the search reaches the last point. The block takes one
// item at a time. Reset clears count, mode and handshake state; the tables are not cleared.
// Depends on psi_pkg and psi_ram.
module path_spline_interpolator #(
  parameter int unsigned MAX_POINTS   = 64,
  parameter int unsigned MIN_SPAN_LSB = 7
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  // Configuration: interp_mode.
  input  logic         cfg_we_i,
  input  logic [1:0]   cfg_wdata_i,
  // Input stream.
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // tdata fields from bit 0: point_x[31:0], point_y[63:32], point_time[95:64],
  // auto_time[96], query_t[128:97], zero fill.
  input  logic [135:0] s_axis_tdata,
  // tuser fields: kind[0].
  input  logic         s_axis_tuser,
  // Output stream.
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // tdata fields from bit 0: out_x[31:0], out_y[63:32], out_time[95:64],
  // status[97:96], zero fill.
  output logic [103:0] m_axis_tdata
);

  localparam int unsigned AW = $clog2(MAX_POINTS);
  localparam int unsigned CW = $clog2(MAX_POINTS + 1);
  localparam logic signed [33:0] MinSpan = 34'(MIN_SPAN_LSB);

  typedef enum logic [2:0] {
    ST_IDLE, ST_SRCH, ST_T0_RD, ST_T0_CAP, ST_DIV, ST_PT, ST_MUL, ST_DONE
  } state_e;

  state_e state_q;
  logic [1:0] mode_q;
  logic [CW-1:0] cnt_q;
  logic [AW-1:0] j_q, i_q;
  logic [16:0] t_q;
  logic signed [31:0] t1_q;
  logic [32:0] span_q;
  logic [32:0] rem_q;
  logic [48:0] num_q;
  logic neg_q;
  logic [5:0] dcnt_q;
  logic [2:0] pc_q;
  logic signed [31:0] px_q [4];
  logic signed [31:0] py_q [4];
  logic signed [19:0] l_q;
  logic signed [21:0] l2_q;
  logic signed [23:0] l3_q;
  logic [2:0] step_q;
  logic phase_q;
  logic signed [61:0] prod_q;
  logic signed [63:0] acc_q;
  logic signed [31:0] res_x_q, res_y_q, res_t_q;
  logic [1:0] res_st_q;
  logic out_v_q;
  logic [103:0] out_q;

  // Input field views.
  logic signed [31:0] in_x, in_y, in_tm, in_q;
  logic in_auto, in_kind;
  assign in_x = s_axis_tdata[31:0];
  assign in_y = s_axis_tdata[63:32];
  assign in_tm = s_axis_tdata[95:64];
  assign in_auto = s_axis_tdata[96];
  assign in_q = s_axis_tdata[128:97];
  assign in_kind = s_axis_tuser;

  logic in_acc;
  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_acc = s_axis_tvalid && s_axis_tready;

  logic cubic;
  assign cubic = (mode_q == psi_pkg::ModeCatmull) || (mode_q == psi_pkg::ModeBezier);

  // Table write happens on the accepting edge of an append with room left.
  logic we;
  logic signed [31:0] wr_tm;
  assign we = in_acc && (in_kind == psi_pkg::KindAppend) && (cnt_q < CW'(MAX_POINTS));
  always_comb begin
    wr_tm = in_tm;
    if (in_auto && in_tm[31]) begin
      wr_tm = (cnt_q == '0) ? 32'sd0 : 32'(psi_pkg::OneQ);
    end
  end

  // Control point indexes around segment i, with the ends duplicated.
  logic [AW-1:0] idx_lo, idx_hi, idx_i1;
  logic [CW:0] i_p2;
  assign idx_i1 = i_q + AW'(1);
  assign i_p2 = (CW + 1)'(i_q) + (CW + 1)'(2);
  assign idx_lo = (i_q != '0) ? i_q - AW'(1) : i_q;
  assign idx_hi = (i_p2 < (CW + 1)'(cnt_q)) ? i_q + AW'(2) : idx_i1;

  logic [AW-1:0] raddr;
  always_comb begin
    unique case (state_q)
      ST_IDLE: raddr = AW'(1);
      ST_SRCH: raddr = j_q + AW'(1);
      ST_PT: begin
        case (pc_q)
          3'd0: raddr = idx_lo;
          3'd1: raddr = i_q;
          3'd2: raddr = idx_i1;
          default: raddr = idx_hi;
        endcase
      end
      default: raddr = i_q;
    endcase
  end

  logic [31:0] x_rd, y_rd, tm_rd;
  psi_ram #(.WIDTH(32), .DEPTH(MAX_POINTS)) u_x_ram (
    .clk_i, .we_i(we), .waddr_i(cnt_q[AW-1:0]), .wdata_i(in_x),
    .raddr_i(raddr), .rdata_o(x_rd)
  );
  psi_ram #(.WIDTH(32), .DEPTH(MAX_POINTS)) u_y_ram (
    .clk_i, .we_i(we), .waddr_i(cnt_q[AW-1:0]), .wdata_i(in_y),
    .raddr_i(raddr), .rdata_o(y_rd)
  );
  psi_ram #(.WIDTH(32), .DEPTH(MAX_POINTS)) u_t_ram (
    .clk_i, .we_i(we), .waddr_i(cnt_q[AW-1:0]), .wdata_i(wr_tm),
    .raddr_i(raddr), .rdata_o(tm_rd)
  );

  // Segment span and signed numerator of the local fraction.
  logic signed [32:0] span_c;
  logic signed [33:0] diff_c;
  logic [32:0] dmag_c;
  assign span_c = 33'(t1_q) - 33'($signed(tm_rd));
  assign diff_c = 34'($signed({1'b0, t_q})) - 34'($signed(tm_rd));
  assign dmag_c = diff_c[33] ? 33'(-diff_c) : diff_c[32:0];

  // One restoring division step per cycle.
  logic [33:0] trial;
  logic [32:0] rem_nx;
  logic [48:0] num_nx;
  logic [18:0] q_sat;
  assign trial = {rem_q, num_q[48]} - {1'b0, span_q};
  always_comb begin
    if (!trial[33]) begin
      rem_nx = trial[32:0];
      num_nx = {num_q[47:0], 1'b1};
    end else begin
      rem_nx = {rem_q[31:0], num_q[48]};
      num_nx = {num_q[47:0], 1'b0};
    end
    q_sat = (num_nx > 49'(psi_pkg::LocalLimit)) ? 19'(psi_pkg::LocalLimit) : num_nx[18:0];
  end

  // Shared multiplier operands; a, b and c come straight from the control points.
  logic signed [36:0] ex0, ex1, ex2, ex3, ey0, ey1, ey2, ey3;
  assign ex0 = 37'(px_q[0]);
  assign ex1 = 37'(px_q[1]);
  assign ex2 = 37'(px_q[2]);
  assign ex3 = 37'(px_q[3]);
  assign ey0 = 37'(py_q[0]);
  assign ey1 = 37'(py_q[1]);
  assign ey2 = 37'(py_q[2]);
  assign ey3 = 37'(py_q[3]);

  logic signed [36:0] mul_a;
  logic signed [24:0] mul_b;
  always_comb begin
    case (step_q)
      3'd0: begin mul_a = 37'(l_q); mul_b = 25'(l_q); end
      3'd1: begin mul_a = 37'(l2_q); mul_b = 25'(l_q); end
      3'd2: begin
        mul_a = cubic ? ex2 - ex0 : ex2 - ex1;
        mul_b = 25'(l_q);
      end
      3'd3: begin mul_a = 2 * ex0 - 5 * ex1 + 4 * ex2 - ex3; mul_b = 25'(l2_q); end
      3'd4: begin mul_a = 3 * ex1 - ex0 - 3 * ex2 + ex3; mul_b = 25'(l3_q); end
      3'd5: begin
        mul_a = cubic ? ey2 - ey0 : ey2 - ey1;
        mul_b = 25'(l_q);
      end
      3'd6: begin mul_a = 2 * ey0 - 5 * ey1 + 4 * ey2 - ey3; mul_b = 25'(l2_q); end
      default: begin mul_a = 3 * ey1 - ey0 - 3 * ey2 + ey3; mul_b = 25'(l3_q); end
    endcase
  end

  logic signed [63:0] acc_sum, fin_cubic, fin_lin;
  logic signed [31:0] p1_sel;
  assign p1_sel = (step_q < 3'd5) ? px_q[1] : py_q[1];
  assign acc_sum = acc_q + 64'(prod_q);
  assign fin_cubic = 64'(p1_sel) + (acc_sum >>> 17);
  assign fin_lin = 64'(p1_sel) + (64'(prod_q) >>> 16);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      mode_q <= psi_pkg::ModeLinear;
      cnt_q <= '0;
      out_v_q <= 1'b0;
      j_q <= '0;
      i_q <= '0;
      pc_q <= '0;
      dcnt_q <= '0;
      step_q <= '0;
      phase_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        mode_q <= cfg_wdata_i;
      end
      if (out_v_q && m_axis_tready) begin
        out_v_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            res_x_q <= '0;
            res_y_q <= '0;
            res_t_q <= '0;
            res_st_q <= psi_pkg::StatusOk;
            state_q <= ST_DONE;
            if (in_kind == psi_pkg::KindAppend) begin
              if (we) begin
                cnt_q <= cnt_q + CW'(1);
              end else begin
                res_st_q <= psi_pkg::StatusFull;
              end
            end else if (cnt_q < CW'(2)) begin
              res_st_q <= psi_pkg::StatusShort;
            end else begin
              // Clamp the query to [0, 1.0].
              if (in_q[31]) begin
                t_q <= '0;
              end else if (in_q > 32'(psi_pkg::OneQ)) begin
                t_q <= 17'(psi_pkg::OneQ);
              end else begin
                t_q <= in_q[16:0];
              end
              j_q <= AW'(1);
              state_q <= ST_SRCH;
            end
          end
        end
        ST_SRCH: begin
          // Read data holds the time of point j.
          if ($signed({15'd0, t_q}) <= $signed(tm_rd)) begin
            t1_q <= tm_rd;
            i_q <= j_q - AW'(1);
            state_q <= ST_T0_RD;
          end else if (CW'(j_q) == cnt_q - CW'(1)) begin
            // Past the end: the last point is returned as is.
            res_x_q <= x_rd;
            res_y_q <= y_rd;
            res_t_q <= tm_rd;
            state_q <= ST_DONE;
          end else begin
            j_q <= j_q + AW'(1);
          end
        end
        ST_T0_RD: begin
          state_q <= ST_T0_CAP;
        end
        ST_T0_CAP: begin
          pc_q <= '0;
          if (34'(span_c) > MinSpan) begin
            span_q <= span_c;
            neg_q <= diff_c[33];
            num_q <= {dmag_c, 16'd0};
            rem_q <= '0;
            dcnt_q <= '0;
            state_q <= ST_DIV;
          end else begin
            l_q <= '0;
            state_q <= ST_PT;
          end
        end
        ST_DIV: begin
          rem_q <= rem_nx;
          num_q <= num_nx;
          dcnt_q <= dcnt_q + 6'd1;
          if (dcnt_q == 6'd48) begin
            l_q <= neg_q ? -20'(q_sat) : 20'(q_sat);
            state_q <= ST_PT;
          end
        end
        ST_PT: begin
          if (pc_q != 3'd0 && pc_q != 3'd4) begin
            px_q[pc_q[1:0] - 2'd1] <= x_rd;
            py_q[pc_q[1:0] - 2'd1] <= y_rd;
          end
          if (pc_q == 3'd4) begin
            px_q[3] <= x_rd;
            py_q[3] <= y_rd;
            step_q <= cubic ? 3'd0 : 3'd2;
            phase_q <= 1'b0;
            state_q <= ST_MUL;
          end else begin
            pc_q <= pc_q + 3'd1;
          end
        end
        ST_MUL: begin
          if (!phase_q) begin
            prod_q <= mul_a * mul_b;
            phase_q <= 1'b1;
          end else begin
            phase_q <= 1'b0;
            step_q <= step_q + 3'd1;
            case (step_q) inside
              3'd0: l2_q <= 22'(prod_q >>> 16);
              3'd1: l3_q <= 24'(prod_q >>> 16);
              3'd2, 3'd5: begin
                acc_q <= 64'(prod_q);
                if (!cubic) begin
                  if (step_q == 3'd2) begin
                    res_x_q <= psi_pkg::sat32(fin_lin);
                    step_q <= 3'd5;
                  end else begin
                    res_y_q <= psi_pkg::sat32(fin_lin);
                    res_t_q <= 32'(t_q);
                    state_q <= ST_DONE;
                  end
                end
              end
              3'd3, 3'd6: acc_q <= acc_sum;
              3'd4: res_x_q <= psi_pkg::sat32(fin_cubic);
              default: begin
                res_y_q <= psi_pkg::sat32(fin_cubic);
                res_t_q <= 32'(t_q);
                state_q <= ST_DONE;
              end
            endcase
          end
        end
        ST_DONE: begin
          // Hand the result to the output register once it is free.
          if (!out_v_q || m_axis_tready) begin
            out_v_q <= 1'b1;
            out_q <= {6'd0, res_st_q, res_t_q, res_y_q, res_x_q};
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata = out_q;

endmodule

// ===== hw/rtl/psi_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// Standalone; no package dependencies.
module psi_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
